### rtl/cdq_pkg.sv
// Shared types and constants of the circular deque block.
// Used by every module of the block but cdq_ram; depends on nothing.
package cdq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;

    typedef enum logic [1:0] {
        FUNC_PUSH_FRONT = 2'd0,
        FUNC_PUSH_REAR  = 2'd1,
        FUNC_POP_FRONT  = 2'd2,
        FUNC_POP_REAR   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;      // perform the operation of the offered word
        logic cap_pop;   // capture the popped word from the read port
        logic load_out;  // load the result into the output register
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_blocked;  // a result is held and the sink stalls
    } dp_status_t;

endpackage

### rtl/cdq_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// Depends on nothing.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### rtl/cdq_ctrl.sv
// Controller state machine of the circular deque.
// Depends on cdq_pkg for the state, command and status types.
module cdq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  cdq_pkg::dp_status_t dp_st,
    output cdq_pkg::ctl_cmd_t   cmd
);

    cdq_pkg::state_t state_reg;
    cdq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_stall     = 1'b1;
        cmd.exec     = 1'b0;
        cmd.cap_pop  = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            cdq_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = cdq_pkg::ST_READ;
                end
            end
            cdq_pkg::ST_READ:
            begin
                cmd.cap_pop = 1'b1;
                state_next  = cdq_pkg::ST_FINISH;
            end
            cdq_pkg::ST_FINISH:
            begin
                if (!dp_st.out_blocked)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = cdq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cdq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/cdq_dp.sv
// Datapath of the circular deque: pointers, count, ring store and output register.
// Depends on cdq_pkg and instantiates cdq_ram.
module cdq_dp #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cdq_pkg::ctl_cmd_t                 cmd,
    output cdq_pkg::dp_status_t               dp_st,
    input  logic [1:0]                        func,
    input  logic signed [cdq_pkg::WORD_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [cdq_pkg::WORD_W-1:0] popped_value,
    output logic [1:0]                        status,
    output logic [CNT_W-1:0]                  entry_count,
    output logic signed [cdq_pkg::WORD_W-1:0] front_value,
    output logic signed [cdq_pkg::WORD_W-1:0] rear_value
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;

    logic                       pop_ok_reg;
    cdq_pkg::status_t           stat_reg;
    logic [cdq_pkg::WORD_W-1:0] popped_reg;
    logic [cdq_pkg::WORD_W-1:0] out_pop_reg, out_front_reg, out_rear_reg;
    cdq_pkg::status_t           out_stat_reg;
    logic [CNT_W-1:0]           out_cnt_reg;

    logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic             is_push, full, empty, op_ok;
    cdq_pkg::status_t stat_calc;

    logic                       we;
    logic [IDX_W-1:0]           waddr, raddr_a;
    logic [cdq_pkg::WORD_W-1:0] rdata_a, rdata_b;

    assign head_inc = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? IDX_LAST : head_reg - 1'b1;
    assign tail_inc = (tail_reg == IDX_LAST) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? IDX_LAST : tail_reg - 1'b1;

    assign is_push = !func[1];
    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);

    always_comb
    begin
        if (is_push && full)
        begin
            stat_calc = cdq_pkg::STAT_FULL;
        end
        else if (!is_push && empty)
        begin
            stat_calc = cdq_pkg::STAT_EMPTY;
        end
        else
        begin
            stat_calc = cdq_pkg::STAT_OK;
        end
    end

    assign op_ok = (stat_calc == cdq_pkg::STAT_OK);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        we         = 1'b0;
        waddr      = tail_reg;
        // Outside the operation cycle the A port reads the front word.
        raddr_a    = head_reg;
        if (cmd.exec && op_ok)
        begin
            case (cdq_pkg::func_t'(func))
                cdq_pkg::FUNC_PUSH_FRONT:
                begin
                    head_next  = head_dec;
                    we         = 1'b1;
                    waddr      = head_dec;
                    count_next = count_reg + 1'b1;
                end
                cdq_pkg::FUNC_PUSH_REAR:
                begin
                    tail_next  = tail_inc;
                    we         = 1'b1;
                    waddr      = tail_reg;
                    count_next = count_reg + 1'b1;
                end
                cdq_pkg::FUNC_POP_FRONT:
                begin
                    head_next  = head_inc;
                    raddr_a    = head_reg;
                    count_next = count_reg - 1'b1;
                end
                cdq_pkg::FUNC_POP_REAR:
                begin
                    tail_next  = tail_dec;
                    raddr_a    = tail_dec;
                    count_next = count_reg - 1'b1;
                end
                default:
                begin
                    head_next = head_reg;
                end
            endcase
        end
    end

    cdq_ram #(
        .WIDTH (cdq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (value),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (tail_dec),
        .rdata_b (rdata_b)
    );

    assign dp_st.out_blocked = out_valid_reg && out_stall;

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            stat_reg   <= stat_calc;
            pop_ok_reg <= !is_push && op_ok;
        end
        if (cmd.cap_pop)
        begin
            popped_reg <= pop_ok_reg ? rdata_a : '0;
        end
        if (cmd.load_out)
        begin
            out_pop_reg   <= popped_reg;
            out_stat_reg  <= stat_reg;
            out_cnt_reg   <= count_reg;
            out_front_reg <= (count_reg == '0) ? '0 : rdata_a;
            out_rear_reg  <= (count_reg == '0) ? '0 : rdata_b;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = out_pop_reg;
    assign status       = out_stat_reg;
    assign entry_count  = out_cnt_reg;
    assign front_value  = out_front_reg;
    assign rear_value   = out_rear_reg;

endmodule

### rtl/circular_deque_top.sv
// Circular deque top level: a double-ended queue of DEPTH words in a ring store.
// Each accepted word passes through the read and finish states, set by the
// registered RAM read ports (the popped word is read first, then the new front
// and rear words). No new word is taken until the last result is loaded.
// Reset (rst_n, asynchronous, active low) empties the deque; store contents stay.
// Depends on cdq_pkg, cdq_ctrl, cdq_dp and cdq_ram.
module circular_deque_top #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        func,
    input  logic signed [cdq_pkg::WORD_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [cdq_pkg::WORD_W-1:0] popped_value,
    output logic [1:0]                        status,
    output logic [CNT_W-1:0]                  entry_count,
    output logic signed [cdq_pkg::WORD_W-1:0] front_value,
    output logic signed [cdq_pkg::WORD_W-1:0] rear_value
);

    // The controller sequences each word through three phases. In the idle
    // phase an offered word is taken and its push or pop is carried out at
    // once: a push writes the store and moves a pointer, a pop issues the
    // read of the word it removes and moves a pointer. In the read phase the
    // popped word is captured and the store is read at the new front and
    // rear. In the finish phase the result is loaded into the output
    // register, which waits there if the sink still holds an older result.
    cdq_pkg::ctl_cmd_t   cmd;
    cdq_pkg::dp_status_t dp_st;

    cdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .dp_st    (dp_st),
        .cmd      (cmd)
    );

    // The datapath holds the head and tail pointers, the fill count, the
    // ring store and the output register. Errors (pop on empty, push on
    // full) leave all state as it was and report a zero popped word.
    cdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .dp_st        (dp_st),
        .func         (func),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .popped_value (popped_value),
        .status       (status),
        .entry_count  (entry_count),
        .front_value  (front_value),
        .rear_value   (rear_value)
    );

endmodule

### rtl/cdq_checker.sv
// Port-level checker of the circular deque, bound to the top level.
// Depends on cdq_pkg and circular_deque_top.
module cdq_checker #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [cdq_pkg::WORD_W-1:0] popped_value,
    input logic [1:0]                 status,
    input logic [CNT_W-1:0]           entry_count,
    input logic [cdq_pkg::WORD_W-1:0] front_value,
    input logic [cdq_pkg::WORD_W-1:0] rear_value
);

    // A held result keeps its word while the sink stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(popped_value)
            && $stable(status) && $stable(entry_count))
    else $error("held result changed under stall");

    // Only one word is in flight: after an accept the input stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while one is in flight");

    // An error never reports a popped word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != cdq_pkg::STAT_OK |-> popped_value == '0)
    else $error("error result carries a popped word");

    // Empty after a step means zero front and rear words; pop on empty means count zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (entry_count == '0 || status == cdq_pkg::STAT_EMPTY)
            |-> front_value == '0 && rear_value == '0 && entry_count == '0)
    else $error("empty deque reports words or count");

    // Push on full only when the count is at capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == cdq_pkg::STAT_FULL |-> entry_count == CNT_W'(DEPTH))
    else $error("full error below capacity");

endmodule

bind circular_deque_top cdq_checker #(
    .DEPTH (DEPTH)
) u_cdq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .popped_value (popped_value),
    .status       (status),
    .entry_count  (entry_count),
    .front_value  (front_value),
    .rear_value   (rear_value)
);

### tb/circular_deque_checker.sv
`timescale 1ns / 100ps
// Checker for the circular deque: watches both word channels, predicts every
// result word from its own deque model and compares it field by field.
// Depends on cdq_pkg for the operation and status codes.
module circular_deque_checker
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [1:0]               func,
    input  logic signed [WORD_W-1:0] value,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [WORD_W-1:0] popped_value,
    input  logic [1:0]               status,
    input  logic [CNT_W-1:0]         entry_count,
    input  logic signed [WORD_W-1:0] front_value,
    input  logic signed [WORD_W-1:0] rear_value,
    output int                       fail_count,
    output int                       pending
);

    typedef struct packed {
        logic [WORD_W-1:0] popped;
        status_t           stat;
        logic [CNT_W-1:0]  count;
        logic [WORD_W-1:0] front;
        logic [WORD_W-1:0] rear;
    } deque_result_t;

    // Model of the deque contents and the results still owed by the block.
    logic [WORD_W-1:0] ring_words [DEPTH];
    int                head_pos;
    int                tail_pos;
    int                fill;
    deque_result_t     owed_q [$];
    int                mismatches = 0;

    function automatic int wrap_dec(input int i);
        return (i == 0) ? DEPTH - 1 : i - 1;
    endfunction

    function automatic int wrap_inc(input int i);
        return (i + 1 >= DEPTH) ? 0 : i + 1;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Applies one operation to the model and returns the result word it owes.
    function automatic deque_result_t deque_step(input func_t op, input logic [WORD_W-1:0] data);
        deque_result_t r;
        r = '0;
        r.stat = STAT_OK;
        if (op == FUNC_PUSH_FRONT || op == FUNC_PUSH_REAR) begin
            if (fill >= DEPTH) begin
                r.stat = STAT_FULL;
            end
            else if (op == FUNC_PUSH_FRONT) begin
                head_pos = wrap_dec(head_pos);
                ring_words[head_pos] = data;
                fill++;
            end
            else begin
                ring_words[tail_pos] = data;
                tail_pos = wrap_inc(tail_pos);
                fill++;
            end
        end
        else begin
            if (fill == 0) begin
                r.stat = STAT_EMPTY;
            end
            else if (op == FUNC_POP_FRONT) begin
                r.popped = ring_words[head_pos];
                head_pos = wrap_inc(head_pos);
                fill--;
            end
            else begin
                tail_pos = wrap_dec(tail_pos);
                r.popped = ring_words[tail_pos];
                fill--;
            end
        end
        if (fill != 0) begin
            r.front = ring_words[head_pos];
            r.rear  = ring_words[wrap_dec(tail_pos)];
        end
        r.count = fill[CNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        deque_result_t want;
        if (!rst_n) begin
            head_pos = 0;
            tail_pos = 0;
            fill     = 0;
            owed_q.delete();
        end
        else begin
            // The result side is checked first, so a word that no accepted
            // input could have caused yet is never matched against a new one.
            if (out_valid && !out_stall) begin
                if (owed_q.size() == 0) begin
                    report_mismatch("result word with nothing expected", popped_value, '0);
                end
                else begin
                    want = owed_q.pop_front();
                    if (popped_value !== want.popped)
                        report_mismatch("popped_value", popped_value, want.popped);
                    if (status !== want.stat)
                        report_mismatch("status", WORD_W'(status), WORD_W'(want.stat));
                    if (entry_count !== want.count)
                        report_mismatch("entry_count", WORD_W'(entry_count),
                                        WORD_W'(want.count));
                    if (front_value !== want.front)
                        report_mismatch("front_value", front_value, want.front);
                    if (rear_value !== want.rear)
                        report_mismatch("rear_value", rear_value, want.rear);
                end
            end
            if (in_valid && !in_stall)
                owed_q.push_back(deque_step(func_t'(func), value));
        end
        fail_count <= mismatches;
        pending    <= owed_q.size();
    end

endmodule

### tb/circular_deque_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the circular deque: clock, reset, stimulus and verdict.
// Depends on cdq_pkg, circular_deque_top and circular_deque_checker.
module circular_deque_top_tb;
    import cdq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    // The slowest correct run, about 1750 words plus the sender gaps and the
    // result stalls of the busiest phases, stays well inside this limit.
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 420;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    func_t                    func      = FUNC_PUSH_FRONT;
    logic signed [WORD_W-1:0] value     = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [WORD_W-1:0] popped_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         entry_count;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    int                       fail_count;
    int                       pending;

    // Percent chances of a sender idle cycle and of a receiver stall cycle.
    int                       idle_pct  = 0;
    int                       stall_pct = 0;
    int                       cycles    = 0;

    always #4 clk = ~clk;

    circular_deque_top #(.DEPTH(DEPTH)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .popped_value (popped_value),
        .status       (status),
        .entry_count  (entry_count),
        .front_value  (front_value),
        .rear_value   (rear_value)
    );

    circular_deque_checker #(.DEPTH(DEPTH)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .popped_value (popped_value),
        .status       (status),
        .entry_count  (entry_count),
        .front_value  (front_value),
        .rear_value   (rear_value),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // The receiver decides afresh at every edge whether it stalls the next cycle.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: a hung handshake or a lost result word ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offers one word and returns at the edge that accepts it. Idle cycles
    // come first, each one a geometric draw, so that idle_pct is the share of
    // idle cycles. Valid is only lowered when a gap is really taken, which
    // keeps back-to-back words free of a low and a high in the same step.
    task automatic send_word(input func_t op, input logic [WORD_W-1:0] data);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        value    <= data;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Data words: mostly random, with the corner values mixed in often.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom_range(1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int    phase;
        int    sent;
        int    burst;
        int    push_pct;
        int    k;
        func_t op;
        int    sender_idle [4];
        int    receiver_stall [4];
        int    push_bias [3];

        // Phases: no idling, a slow sender, a slow receiver, and both lightly.
        sender_idle    = '{0, 67, 0, 6};
        receiver_stall = '{0, 0, 67, 6};
        // Bursts lean toward pushes, toward pops, or neither, so the deque
        // keeps wandering between empty and full and hits both errors.
        push_bias      = '{15, 50, 85};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Pops on an empty deque from both ends come first.
        send_word(FUNC_POP_FRONT, 32'hFFFF_FFFF);
        send_word(FUNC_POP_REAR, 32'h0000_0000);
        // One word at each end, then taken back from each end.
        send_word(FUNC_PUSH_FRONT, 32'h7FFF_FFFF);
        send_word(FUNC_PUSH_REAR, 32'h8000_0000);
        send_word(FUNC_POP_FRONT, 32'h0000_0000);
        send_word(FUNC_POP_REAR, 32'h0000_0000);
        // Fill to capacity from both ends; the head index wraps on the way.
        for (k = 0; k < DEPTH; k++) begin
            case (k % 4)
                0:       send_word(FUNC_PUSH_FRONT, 32'h8000_0000);
                1:       send_word(FUNC_PUSH_REAR, 32'h7FFF_FFFF);
                2:       send_word(FUNC_PUSH_FRONT, 32'hFFFF_FFFF);
                default: send_word(FUNC_PUSH_REAR, $urandom);
            endcase
        end
        // Pushes on a full deque at either end are refused.
        send_word(FUNC_PUSH_FRONT, 32'h1234_5678);
        send_word(FUNC_PUSH_REAR, 32'h8765_4321);

        // Random part, one block of words per idling phase.
        for (phase = 0; phase < 4; phase++) begin
            idle_pct  = sender_idle[phase];
            stall_pct = receiver_stall[phase];
            sent      = 0;
            while (sent < PHASE_WORDS) begin
                push_pct = push_bias[$urandom_range(2)];
                burst    = $urandom_range(40, 4);
                for (k = 0; k < burst; k++) begin
                    if ($urandom_range(99) < push_pct)
                        op = $urandom_range(1) ? FUNC_PUSH_REAR : FUNC_PUSH_FRONT;
                    else
                        op = $urandom_range(1) ? FUNC_POP_REAR : FUNC_POP_FRONT;
                    send_word(op, pick_word());
                    sent++;
                end
            end
        end

        // Drain: stop offering, let the receiver take everything, then let the
        // block run on so that any stray result word shows.
        in_valid  <= 1'b0;
        stall_pct = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/cdq_ctrl.sv
rtl/cdq_dp.sv
rtl/circular_deque_top.sv
rtl/cdq_checker.sv
tb/circular_deque_checker.sv
tb/circular_deque_top_tb.sv
